/* hdl/wqmw_pkg.sv */
// ----------------------------------------------------------------------------
// wqmw_pkg
// Shared sizes, codes and beat types for the wait queue with missed wakeups.
// ----------------------------------------------------------------------------
package wqmw_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 8;
  localparam int MISSED_BITS = 8;

  localparam int IDX_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] OP_SLEEP   = 2'd0;
  localparam logic [1:0] OP_WAKE    = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;

  localparam logic [2:0] ST_OK_ATOMIC   = 3'd0;
  localparam logic [2:0] ST_WOULD_BLOCK = 3'd1;
  localparam logic [2:0] ST_ENQUEUED    = 3'd2;
  localparam logic [2:0] ST_FULL        = 3'd3;
  localparam logic [2:0] ST_WOKEN       = 3'd4;
  localparam logic [2:0] ST_MISSED      = 3'd5;
  localparam logic [2:0] ST_REMOVED     = 3'd6;
  localparam logic [2:0] ST_NOT_FOUND   = 3'd7;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] thread_id;
    logic       has_timeout;
    logic       nonblocking;
    logic       wake_all;
  } in_beat_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] woken_id;
    logic       last;
  } out_beat_t;

  typedef struct packed {
    logic                we;
    logic [IDX_BITS-1:0] waddr;
    logic [ID_BITS-1:0]  wdata;
    logic [IDX_BITS-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [IDX_BITS-1:0] nxt_idx;
    logic                more;
    logic                match;
  } alu_res_t;

endpackage

/* hdl/wqmw_store.sv */
// ----------------------------------------------------------------------------
// wqmw_store
// Sleeper id storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module wqmw_store import wqmw_pkg::*; (
  input  logic               clk,
  input  mem_req_t           req,
  output logic [ID_BITS-1:0] rd_data
);

  logic [ID_BITS-1:0] sleeper_mem [QUEUE_DEPTH];
  logic [ID_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      sleeper_mem[req.waddr] <= req.wdata;
    end
    rd_data_r <= sleeper_mem[req.raddr];
  end

  assign rd_data = rd_data_r;

endmodule

/* hdl/wqmw_alu.sv */
// ----------------------------------------------------------------------------
// wqmw_alu
// Shared walk unit: index step, end-of-queue test and id compare.
// ----------------------------------------------------------------------------
module wqmw_alu import wqmw_pkg::*; (
  input  logic [IDX_BITS-1:0] idx,
  input  logic [CNT_BITS-1:0] count,
  input  logic [ID_BITS-1:0]  rd_data,
  input  logic [ID_BITS-1:0]  tid,
  output alu_res_t            res
);

  logic [CNT_BITS-1:0] inc;

  always_comb begin
    inc         = CNT_BITS'(idx) + CNT_BITS'(1);
    res.nxt_idx = inc[IDX_BITS-1:0];
    res.more    = (inc < count);
    res.match   = (rd_data == tid);
  end

endmodule

/* hdl/wqmw_ctrl.sv */
// ----------------------------------------------------------------------------
// wqmw_ctrl
// Sequencer: dispatches one request, walks and compacts the queue, and
// holds the output register.
// ----------------------------------------------------------------------------
module wqmw_ctrl import wqmw_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_beat_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_beat_t          out_data,
  output mem_req_t           mem_req,
  input  logic [ID_BITS-1:0] rd_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_SHRD = 3'd4;
  localparam logic [2:0] S_SHWR = 3'd5;

  logic [2:0]             state_r, state_nxt;
  in_beat_t               item_r, item_nxt;
  logic [IDX_BITS-1:0]    idx_r, idx_nxt;
  logic [CNT_BITS-1:0]    count_r, count_nxt;
  logic [MISSED_BITS-1:0] missed_r, missed_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_beat_t              out_data_r, out_data_nxt;

  logic               out_free;
  logic               emit;
  out_beat_t          res_beat;
  logic [ID_BITS-1:0] tid;
  alu_res_t           alu;

  assign tid      = ID_BITS'(item_r.thread_id);
  assign out_free = !out_valid_r || !out_stall;

  wqmw_alu u_alu (
    .idx     (idx_r),
    .count   (count_r),
    .rd_data (rd_data),
    .tid     (tid),
    .res     (alu)
  );

  always_comb begin
    state_nxt  = state_r;
    item_nxt   = item_r;
    idx_nxt    = idx_r;
    count_nxt  = count_r;
    missed_nxt = missed_r;
    emit       = 1'b0;
    res_beat   = '{status: ST_OK_ATOMIC, woken_id: 8'd0, last: 1'b1};
    mem_req.we    = 1'b0;
    mem_req.waddr = idx_r;
    mem_req.wdata = rd_data;
    mem_req.raddr = (state_r == S_SHRD) ? alu.nxt_idx : idx_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        idx_nxt = '0;
        case (item_r.op)
          OP_SLEEP: begin
            if (out_free) begin
              emit      = 1'b1;
              state_nxt = S_IDLE;
              if (missed_r != '0) begin
                missed_nxt      = missed_r - MISSED_BITS'(1);
                res_beat.status = ST_OK_ATOMIC;
              end else if (item_r.nonblocking && !item_r.has_timeout) begin
                res_beat.status = ST_WOULD_BLOCK;
              end else if (count_r == CNT_BITS'(QUEUE_DEPTH)) begin
                res_beat.status = ST_FULL;
              end else begin
                mem_req.we      = 1'b1;
                mem_req.waddr   = count_r[IDX_BITS-1:0];
                mem_req.wdata   = tid;
                count_nxt       = count_r + CNT_BITS'(1);
                res_beat.status = ST_ENQUEUED;
              end
            end
          end
          OP_WAKE: begin
            if (count_r != '0) begin
              state_nxt = S_RD;
            end else if (out_free) begin
              emit            = 1'b1;
              res_beat.status = ST_MISSED;
              state_nxt       = S_IDLE;
              if (item_r.wake_all) begin
                missed_nxt = '0;
              end else if (missed_r != '1) begin
                missed_nxt = missed_r + MISSED_BITS'(1);
              end
            end
          end
          OP_TIMEOUT: begin
            if (count_r != '0) begin
              state_nxt = S_RD;
            end else if (out_free) begin
              emit            = 1'b1;
              res_beat.status = ST_NOT_FOUND;
              state_nxt       = S_IDLE;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        // rd_data holds the entry at idx_r
        if (item_r.op == OP_WAKE) begin
          if (out_free) begin
            emit              = 1'b1;
            res_beat.status   = ST_WOKEN;
            res_beat.woken_id = 8'(rd_data);
            if (!item_r.wake_all) begin
              state_nxt = S_SHRD;
            end else begin
              res_beat.last = !alu.more;
              if (alu.more) begin
                idx_nxt   = alu.nxt_idx;
                state_nxt = S_RD;
              end else begin
                count_nxt  = '0;
                missed_nxt = '0;
                state_nxt  = S_IDLE;
              end
            end
          end
        end else if (alu.match) begin
          if (out_free) begin
            emit              = 1'b1;
            res_beat.status   = ST_REMOVED;
            res_beat.woken_id = 8'(tid);
            state_nxt         = S_SHRD;
          end
        end else if (alu.more) begin
          idx_nxt   = alu.nxt_idx;
          state_nxt = S_RD;
        end else if (out_free) begin
          emit            = 1'b1;
          res_beat.status = ST_NOT_FOUND;
          state_nxt       = S_IDLE;
        end
      end
      S_SHRD: begin
        // close the gap at idx_r: fetch the entry behind it, or finish
        if (alu.more) begin
          state_nxt = S_SHWR;
        end else begin
          count_nxt = count_r - CNT_BITS'(1);
          state_nxt = S_IDLE;
        end
      end
      S_SHWR: begin
        mem_req.we = 1'b1;
        idx_nxt    = alu.nxt_idx;
        state_nxt  = S_SHRD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_beat;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      missed_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      missed_r    <= missed_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r     <= item_nxt;
    idx_r      <= idx_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* hdl/wait_queue_with_missed_wakeups.sv */
// ----------------------------------------------------------------------------
// wait_queue_with_missed_wakeups
// Wait queue of sleeping thread ids with a saturating missed-wakeup count.
// ----------------------------------------------------------------------------
// Requests arrive on the in_ channel (valid/stall), one beat per sleep,
// wakeup or timeout expiry. Results leave on the out_ channel, one beat per
// result, last set on the final beat of a request.
// One request is worked at a time; in_stall is high from the cycle after a
// beat is taken until its work is done. The sequencer steps through the
// sleeper store, one registered read per entry. A single wakeup takes the
// head and compacts the queue behind it; wake-all walks every sleeper; a
// timeout scans for its thread and, if found, compacts the queue behind it.
// A finished result sits in the output register; a stalled receiver holds
// the sequencer at its next result, while a request may already be taken.
// Reset (synchronous, rst_n low) empties the queue and clears the missed
// count and the output valid flag; sleeper ids need no clearing.
// ----------------------------------------------------------------------------
module wait_queue_with_missed_wakeups import wqmw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  mem_req_t           mem_req;
  logic [ID_BITS-1:0] rd_data;

  wqmw_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  wqmw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .mem_req   (mem_req),
    .rd_data   (rd_data)
  );

endmodule

/* hdl/wqmw_checker.sv */
// ----------------------------------------------------------------------------
// wqmw_checker
// Port-level checks for the wait queue, bound to the top level.
// ----------------------------------------------------------------------------
module wqmw_checker import wqmw_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_beat_t out_data
);

  // a held result beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // one request at a time
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while previous one in flight");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat valid after reset");

  // only wake-all gives more than one result
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_WOKEN |-> out_data.last)
    else $error("single-result status without last");

  a_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_WOKEN && out_data.status != ST_REMOVED
      |-> out_data.woken_id == 8'd0)
    else $error("woken_id set for a status that carries no id");

endmodule

bind wait_queue_with_missed_wakeups wqmw_checker u_wqmw_checker (.*);

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the wait queue with missed wakeups.
// ----------------------------------------------------------------------------
// A behavioural copy of the queue and the missed-wakeup count predicts every
// result beat as requests are taken. Result beats are compared field by field
// in order. The run starts with directed requests covering the corner cases:
// missed wakeups, would-block, full queue, removal, wake-all and the unused
// op. It then mixes random request sequences with random gaps on both sides.
// It also holds the receiver off for a long stretch and saturates the
// missed count once.
// ----------------------------------------------------------------------------
module tb_top;
  import wqmw_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 380;
  localparam int IDLE_LIMIT   = 3000;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 200;

  // queue model plus the results it still owes
  class wait_queue_tracker;
    logic [ID_BITS-1:0]     sleepers[$];
    logic [MISSED_BITS-1:0] missed;
    out_beat_t              due_results[$];
    int                     errors;

    function new();
      missed = '0;
      errors = 0;
    endfunction

    function void owe(logic [2:0] st, logic [7:0] id, logic lst);
      out_beat_t r;
      r.status   = st;
      r.woken_id = id;
      r.last     = lst;
      due_results.push_back(r);
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void note_request(in_beat_t b);
      int hit;
      hit = -1;
      case (b.op)
        OP_SLEEP: begin
          if (missed != '0) begin
            missed = missed - 1'b1;
            owe(ST_OK_ATOMIC, 8'd0, 1'b1);
          end else if (b.nonblocking && !b.has_timeout) begin
            owe(ST_WOULD_BLOCK, 8'd0, 1'b1);
          end else if (sleepers.size() >= QUEUE_DEPTH) begin
            owe(ST_FULL, 8'd0, 1'b1);
          end else begin
            sleepers.push_back(b.thread_id);
            owe(ST_ENQUEUED, 8'd0, 1'b1);
          end
        end
        OP_WAKE: begin
          if (sleepers.size() == 0) begin
            if (b.wake_all) missed = '0;
            else if (missed != '1) missed = missed + 1'b1;
            owe(ST_MISSED, 8'd0, 1'b1);
          end else if (!b.wake_all) begin
            owe(ST_WOKEN, sleepers.pop_front(), 1'b1);
          end else begin
            for (int i = 0; i < sleepers.size(); i++)
              owe(ST_WOKEN, sleepers[i], i == sleepers.size() - 1);
            sleepers.delete();
            missed = '0;
          end
        end
        OP_TIMEOUT: begin
          foreach (sleepers[i])
            if (hit < 0 && sleepers[i] == b.thread_id) hit = i;
          if (hit >= 0) begin
            sleepers.delete(hit);
            owe(ST_REMOVED, b.thread_id, 1'b1);
          end else begin
            owe(ST_NOT_FOUND, 8'd0, 1'b1);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(out_beat_t r);
      out_beat_t e;
      if (due_results.size() == 0) begin
        $error("unexpected result beat: status %0d woken_id %0d last %0d",
               r.status, r.woken_id, r.last);
        errors++;
        return;
      end
      e = due_results.pop_front();
      if (r.status !== e.status) begin
        $error("field status: expected %0d, got %0d", e.status, r.status);
        errors++;
      end
      if (r.woken_id !== e.woken_id) begin
        $error("field woken_id: expected %0d, got %0d", e.woken_id, r.woken_id);
        errors++;
      end
      if (r.last !== e.last) begin
        $error("field last: expected %0d, got %0d", e.last, r.last);
        errors++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_data;

  wait_queue_tracker wq = new();

  int quiet_cycles = 0;
  int counted      = 0;
  bit counting     = 1'b0;
  bit calm_send    = 1'b0;
  bit want_hold    = 1'b0;

  wait_queue_with_missed_wakeups dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic in_beat_t beat(logic [1:0] op, logic [7:0] id, logic ht, logic nb,
                                    logic wa);
    in_beat_t b;
    b.op          = op;
    b.thread_id   = id;
    b.has_timeout = ht;
    b.nonblocking = nb;
    b.wake_all    = wa;
    return b;
  endfunction

  // small pool half the time so duplicate ids turn up
  function automatic logic [7:0] pick_id();
    if ($urandom_range(0, 1)) return 8'($urandom_range(0, 7));
    return 8'($urandom);
  endfunction

  task automatic offer(input in_beat_t b);
    int gap;
    gap = calm_send ? 0 : gap_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (counting && b.op != OP_UNUSED) counted++;
  endtask

  // stop offering, let the last accepted request be noted, then wait for all results
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (wq.pending() != 0) @(posedge clk);
  endtask

  task automatic offer_sleeps(input int n);
    logic nb;
    logic ht;
    repeat (n) begin
      if ($urandom_range(0, 7) == 0) begin
        nb = 1'b1;
        ht = 1'b0;
      end else begin
        nb = 1'($urandom_range(0, 1));
        ht = nb ? 1'b1 : 1'($urandom_range(0, 1));
      end
      offer(beat(OP_SLEEP, pick_id(), ht, nb, 1'($urandom_range(0, 1))));
    end
  endtask

  task automatic offer_timeouts(input int n);
    logic [7:0] id;
    repeat (n) begin
      if (wq.sleepers.size() > 0 && $urandom_range(0, 3) != 0)
        id = wq.sleepers[$urandom_range(0, wq.sleepers.size() - 1)];
      else
        id = pick_id();
      offer(beat(OP_TIMEOUT, id, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1))));
    end
  endtask

  // empty the queue, push the missed count to all ones, use a few, then clear
  task automatic saturate_missed();
    offer(beat(OP_WAKE, pick_id(), 1'b0, 1'b0, 1'b1));
    repeat ((1 << MISSED_BITS) + 4)
      offer(beat(OP_WAKE, 8'($urandom), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), 1'b0));
    offer_sleeps(3);
    offer(beat(OP_WAKE, 8'($urandom), 1'b0, 1'b0, 1'b1));
  endtask

  // requests are noted before results so a beat never overtakes its cause
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) wq.note_request(in_data);
      if (out_valid && !out_stall) wq.check_result(out_data);
    end
  end

  initial begin
    while (quiet_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("status: fail");
    $finish;
  end

  // receiver: random stalls, calm stretches, one long hold-off on request
  initial begin
    int n;
    out_stall <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (want_hold) begin
        want_hold = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if ($urandom_range(0, 19) == 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end else begin
        n = gap_cycles();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      @(posedge clk);
    end
  end

  initial begin
    int  pick;
    bit  hold_asked;
    bit  burst_done;
    hold_asked = 1'b0;
    burst_done = 1'b0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners
    offer(beat(OP_WAKE, 8'h00, 1'b0, 1'b0, 1'b0));
    offer(beat(OP_SLEEP, 8'h00, 1'b0, 1'b1, 1'b0));
    offer(beat(OP_SLEEP, 8'hFF, 1'b0, 1'b1, 1'b1));
    offer(beat(OP_WAKE, 8'hFF, 1'b1, 1'b1, 1'b1));
    offer(beat(OP_TIMEOUT, 8'hFF, 1'b0, 1'b0, 1'b0));
    offer(beat(OP_UNUSED, 8'hFF, 1'b1, 1'b1, 1'b1));
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      logic [7:0] id;
      logic [3:0] k;
      k = 4'(i);
      case (i)
        0:       id = 8'h00;
        1:       id = 8'hFF;
        2, 4:    id = 8'h55;
        3:       id = 8'hAA;
        default: id = 8'(i * 37 + 3);
      endcase
      offer(beat(OP_SLEEP, id, k[0] | k[1], k[1], k[2]));
    end
    offer(beat(OP_SLEEP, 8'h12, 1'b1, 1'b0, 1'b0));
    offer(beat(OP_TIMEOUT, 8'h55, 1'b1, 1'b1, 1'b1));
    offer(beat(OP_WAKE, 8'h00, 1'b0, 1'b0, 1'b0));
    offer(beat(OP_WAKE, 8'h00, 1'b0, 1'b0, 1'b1));
    wait_drained();

    counting = 1'b1;
    while (counted < RANDOM_ITEMS) begin
      calm_send = ($urandom_range(0, 4) == 0);
      if (!hold_asked && counted >= 30) begin
        hold_asked = 1'b1;
        want_hold  = 1'b1;
      end
      if (!burst_done && counted >= 60) begin
        burst_done = 1'b1;
        saturate_missed();
      end
      pick = $urandom_range(0, 99);
      if (pick < 32) offer_sleeps($urandom_range(1, 18));
      else if (pick < 48)
        repeat ($urandom_range(1, 3)) offer(beat(OP_WAKE, pick_id(), 1'($urandom_range(0, 1)),
                                                 1'($urandom_range(0, 1)), 1'b0));
      else if (pick < 56) offer(beat(OP_WAKE, pick_id(), 1'($urandom_range(0, 1)),
                                     1'($urandom_range(0, 1)), 1'b1));
      else if (pick < 74) offer_timeouts($urandom_range(1, 3));
      else if (pick < 92)
        repeat ($urandom_range(1, 4)) offer(in_beat_t'(13'($urandom)));
      else wait_drained();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (wq.errors == 0 && wq.pending() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

/* wait_queue_with_missed_wakeups.f */
hdl/wqmw_pkg.sv
hdl/wqmw_store.sv
hdl/wqmw_alu.sv
hdl/wqmw_ctrl.sv
hdl/wait_queue_with_missed_wakeups.sv
hdl/wqmw_checker.sv
test/tb_top.sv
